FILE: hdl/slpi_pkg.sv
// shared constants, codes and types of the sample player voice
`timescale 1ns / 1ps
`default_nettype none

package slpi_pkg;

    // fixed field widths
    localparam int LEN_BITS       = 13;
    localparam int SPEED_BITS     = 20;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OP_BITS        = 2;

    localparam logic [SPEED_BITS-1:0] SPEED_RESET = 20'd65536;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // item operations
    localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_BITS-1:0] OP_PLAY = 2'd1;
    localparam logic [OP_BITS-1:0] OP_STOP = 2'd2;
    localparam logic [OP_BITS-1:0] OP_TICK = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_STEP    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_ENABLE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_LENGTH = 2'd2;

    // how a tick builds its output
    localparam logic [1:0] MODE_ZERO   = 2'd0;
    localparam logic [1:0] MODE_RAW    = 2'd1;
    localparam logic [1:0] MODE_INTERP = 2'd2;

    // control part of a command travelling from front to back
    typedef struct packed {
        logic       is_load;
        logic [1:0] mode;
        logic       still;
    } slpi_ctl_t;

    localparam int CTL_BITS = $bits(slpi_ctl_t);

endpackage

`default_nettype wire

FILE: hdl/slpi_fifo.sv
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
`default_nettype none

module slpi_fifo #(
    parameter int WIDTH    = 8,
    parameter int DEPTH    = 4,
    parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    output logic                full,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output logic                empty,
    output logic [CNT_BITS-1:0] count
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full  = (count_reg == CNT_BITS'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/slpi_front.sv
// front end: configuration, playhead and play state, command classification
`timescale 1ns / 1ps
`default_nettype none

module slpi_front #(
    parameter int SAMPLE_DEPTH = 4096,
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_BITS  = 16,
    parameter int ADDR_BITS    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1,
    parameter int CMD_BITS     = slpi_pkg::CTL_BITS + ADDR_BITS + SAMPLE_BITS + FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic [slpi_pkg::OP_BITS-1:0]         operation,
    input  logic [11:0]                          load_address,
    input  logic [SAMPLE_BITS-1:0]               sample_value,
    input  logic                                 cfg_write,
    input  logic [slpi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [slpi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                 cmd_push,
    output logic [CMD_BITS-1:0]                  cmd_data
);

    import slpi_pkg::*;

    localparam int IDX_BITS = (ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS;
    localparam int CMP_BITS = IDX_BITS + 1;
    localparam int PH_BITS  = LEN_BITS + FRAC_BITS;

    logic [SPEED_BITS-1:0] speed_reg;
    logic                  loop_reg;
    logic [LEN_BITS-1:0]   length_reg;
    logic [PH_BITS-1:0]    playhead_reg;
    logic                  playing_reg;

    logic [LEN_BITS-1:0]   len_eff;
    logic [LEN_BITS-1:0]   ph_idx;
    logic [FRAC_BITS-1:0]  ph_frac;
    logic                  active;
    logic [LEN_BITS:0]     idx_inc;
    logic [1:0]            tick_mode;
    logic [PH_BITS:0]      end_pos;
    logic [PH_BITS:0]      ph_sum;
    logic [PH_BITS:0]      ph_wrap;
    logic                  reached;
    logic [PH_BITS-1:0]    ph_adv;
    logic                  play_adv;
    logic [IDX_BITS-1:0]   idx_wide;
    logic [IDX_BITS-1:0]   addr_wide;
    logic                  addr_ok;
    slpi_ctl_t             ctl;
    logic [ADDR_BITS-1:0]  cmd_addr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_RESET;
            loop_reg   <= 1'b0;
            length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SPEED_STEP:    speed_reg  <= cfg_data[SPEED_BITS-1:0];
                CFG_LOOP_ENABLE:   loop_reg   <= cfg_data[0];
                CFG_SAMPLE_LENGTH: length_reg <= cfg_data[LEN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // playhead arithmetic
    always_comb
    begin
        len_eff  = (CMP_BITS'(length_reg) > CMP_BITS'(SAMPLE_DEPTH)) ?
                   LEN_BITS'(SAMPLE_DEPTH) : length_reg;
        ph_idx   = playhead_reg[PH_BITS-1:FRAC_BITS];
        ph_frac  = playhead_reg[FRAC_BITS-1:0];
        active   = playing_reg && (len_eff != '0);
        idx_inc  = {1'b0, ph_idx} + 1'b1;

        if (!active)
        begin
            tick_mode = MODE_ZERO;
        end
        else if (idx_inc < {1'b0, len_eff})
        begin
            tick_mode = MODE_INTERP;
        end
        else if (ph_idx < len_eff)
        begin
            tick_mode = MODE_RAW;
        end
        else
        begin
            tick_mode = MODE_ZERO;
        end

        end_pos  = {1'b0, len_eff, {FRAC_BITS{1'b0}}};
        ph_sum   = {1'b0, playhead_reg} + (PH_BITS + 1)'(speed_reg);
        ph_wrap  = ph_sum - end_pos;
        reached  = (ph_sum >= end_pos);
        ph_adv   = (reached && loop_reg) ? ph_wrap[PH_BITS-1:0] : ph_sum[PH_BITS-1:0];
        play_adv = playing_reg && !(reached && !loop_reg);

        idx_wide  = IDX_BITS'(ph_idx);
        addr_wide = IDX_BITS'(load_address);
        addr_ok   = (CMP_BITS'(load_address) < CMP_BITS'(SAMPLE_DEPTH));
    end

    // play state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playhead_reg <= '0;
            playing_reg  <= 1'b0;
        end
        else if (item_valid)
        begin
            unique case (operation)
                OP_LOAD:
                begin
                    playhead_reg <= '0;
                end
                OP_PLAY:
                begin
                    playhead_reg <= '0;
                    playing_reg  <= 1'b1;
                end
                OP_STOP:
                begin
                    playhead_reg <= '0;
                    playing_reg  <= 1'b0;
                end
                OP_TICK:
                begin
                    if (active)
                    begin
                        playhead_reg <= ph_adv;
                        playing_reg  <= play_adv;
                    end
                end
            endcase
        end
    end

    // command to the back end: loads in range and every tick
    always_comb
    begin
        ctl.is_load = (operation == OP_LOAD);
        ctl.mode    = tick_mode;
        ctl.still   = active ? play_adv : playing_reg;
        cmd_addr    = ctl.is_load ? addr_wide[ADDR_BITS-1:0] : idx_wide[ADDR_BITS-1:0];
        cmd_push    = item_valid &&
                      (((operation == OP_LOAD) && addr_ok) || (operation == OP_TICK));
        cmd_data    = {ctl, cmd_addr, sample_value, ph_frac};
    end

`ifndef SYNTHESIS
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && (operation == OP_STOP) |=> !playing_reg && (playhead_reg == '0))
        else $error("stop did not clear the play state");

    a_zero_len_holds: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && (operation == OP_TICK) && (len_eff == '0) |=> $stable(playhead_reg))
        else $error("playhead moved with zero length");

    a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && (operation == OP_TICK) && !playing_reg
        |-> cmd_push && (ctl.mode == MODE_ZERO) && !ctl.still)
        else $error("idle tick not classified as silent");
`endif

endmodule

`default_nettype wire

FILE: hdl/slpi_back.sv
// back end: sample memory, interpolation pipeline and output credit check
`timescale 1ns / 1ps
`default_nettype none

module slpi_back #(
    parameter int SAMPLE_DEPTH = 4096,
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_BITS  = 16,
    parameter int ADDR_BITS    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1,
    parameter int CMD_BITS     = slpi_pkg::CTL_BITS + ADDR_BITS + SAMPLE_BITS + FRAC_BITS,
    parameter int OCNT_BITS    = $clog2(slpi_pkg::OUT_DEPTH + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_empty,
    input  logic [CMD_BITS-1:0]    cmd_data,
    output logic                   cmd_pop,
    input  logic [OCNT_BITS-1:0]   out_count,
    output logic                   out_push,
    output logic [SAMPLE_BITS:0]   out_data
);

    import slpi_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

    slpi_ctl_t                ctl;
    logic [ADDR_BITS-1:0]     addr;
    logic [ADDR_BITS-1:0]     addr_inc;
    logic [SAMPLE_BITS-1:0]   data;
    logic [FRAC_BITS-1:0]     frac;
    logic [OCNT_BITS:0]       credit_used;
    logic                     credit_ok;

    logic [SAMPLE_BITS-1:0]   sample_mem_reg [SAMPLE_DEPTH];
    logic [SAMPLE_BITS-1:0]   rd0_reg;
    logic [SAMPLE_BITS-1:0]   rd1_reg;

    logic                     v1_reg;
    logic [1:0]               mode1_reg;
    logic                     still1_reg;
    logic [FRAC_BITS-1:0]     frac1_reg;

    logic                     v2_reg;
    logic [1:0]               mode2_reg;
    logic                     still2_reg;
    logic [SAMPLE_BITS-1:0]   s0_2_reg;
    logic signed [PROD_BITS-1:0] prod2_reg;

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_BITS-1:0] prod;
    logic [SAMPLE_BITS-1:0]      audio;

    assign {ctl, addr, data, frac} = cmd_data;
    assign addr_inc = addr + 1'b1;

    // results in flight plus results queued must fit the output queue
    assign credit_used = (OCNT_BITS + 1)'(out_count) + (OCNT_BITS + 1)'(v1_reg)
                       + (OCNT_BITS + 1)'(v2_reg);
    assign credit_ok   = (credit_used < (OCNT_BITS + 1)'(OUT_DEPTH));
    assign cmd_pop     = !cmd_empty && (ctl.is_load || credit_ok);

    // sample memory: one write or one read pair per cycle while commands are popped, in command order
    always_ff @(posedge clk)
    begin
        if (cmd_pop && ctl.is_load)
        begin
            sample_mem_reg[addr] <= data;
        end
        if (cmd_pop && !ctl.is_load)
        begin
            rd0_reg <= sample_mem_reg[addr];
            rd1_reg <= sample_mem_reg[addr_inc];
        end
    end

    always_comb
    begin
        diff   = $signed({rd1_reg[SAMPLE_BITS-1], rd1_reg})
               - $signed({rd0_reg[SAMPLE_BITS-1], rd0_reg});
        frac_s = $signed({1'b0, frac1_reg});
        prod   = diff * frac_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd_pop && !ctl.is_load;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && !ctl.is_load)
        begin
            mode1_reg  <= ctl.mode;
            still1_reg <= ctl.still;
            frac1_reg  <= frac;
        end
        if (v1_reg)
        begin
            mode2_reg  <= mode1_reg;
            still2_reg <= still1_reg;
            s0_2_reg   <= rd0_reg;
            prod2_reg  <= prod;
        end
    end

    // in interp mode the floor of s0 + diff * frac / 2^frac_bits, between s0 and s1; raw mode gives s0, else zero
    always_comb
    begin
        unique case (mode2_reg)
            MODE_RAW:    audio = s0_2_reg;
            MODE_INTERP: audio = s0_2_reg
                               + prod2_reg[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
            default:     audio = '0;
        endcase
    end

    assign out_push = v2_reg;
    assign out_data = {audio, still2_reg};

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count < OCNT_BITS'(OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (OCNT_BITS + 1)'(OUT_DEPTH))
        else $error("results in flight exceed output queue room");

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_empty && (out_count == '0) |-> cmd_pop)
        else $error("back end stalled with an empty output queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/sample_player_linear_interp_top.sv
// top level: sample playback voice with linear interpolation
// a tick's result goes through the command queue, the read and product registers, then the output queue
// throughput: one beat per cycle while the command queue has room, set by the single read pair of the sample memory
// loads, play and stop give no result; loads in range also write the sample memory via the command queue
// reset (rst_n low, asynchronous) resets playhead, play flag, registers and both queues
// sample memory is not cleared: entries hold nothing defined until loaded
`timescale 1ns / 1ps
`default_nettype none

module sample_player_linear_interp_top #(
    parameter int SAMPLE_DEPTH = 4096,
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item side
    input  logic                                push,
    output logic                                full,
    input  logic [slpi_pkg::OP_BITS-1:0]        operation,
    input  logic [11:0]                         load_address,
    input  logic [SAMPLE_BITS-1:0]              sample_value,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [SAMPLE_BITS-1:0]              audio_out,
    output logic                                still_playing,
    // configuration
    input  logic                                cfg_write,
    input  logic [slpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [slpi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import slpi_pkg::*;

    localparam int ADDR_BITS = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CMD_BITS  = CTL_BITS + ADDR_BITS + SAMPLE_BITS + FRAC_BITS;
    localparam int OCNT_BITS = $clog2(OUT_DEPTH + 1);

    logic                   item_valid;
    logic                   cmd_push;
    logic [CMD_BITS-1:0]    cmd_wdata;
    logic                   cmd_full;
    logic                   cmd_empty;
    logic                   cmd_pop;
    logic [CMD_BITS-1:0]    cmd_rdata;
    logic                   out_push;
    logic [SAMPLE_BITS:0]   out_wdata;
    logic [SAMPLE_BITS:0]   out_rdata;
    logic [OCNT_BITS-1:0]   out_count;

    // a beat is taken whenever the command queue has room
    assign full       = cmd_full;
    assign item_valid = push && !cmd_full;

    // front end: owns playhead and play flag, so it never waits on the memory
    slpi_front #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_BITS    (ADDR_BITS),
        .CMD_BITS     (CMD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .operation    (operation),
        .load_address (load_address),
        .sample_value (sample_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_wdata)
    );

    // command queue between front and back keeps loads and ticks in order
    slpi_fifo #(
        .WIDTH     (CMD_BITS),
        .DEPTH     (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_wdata),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_rdata),
        .empty     (cmd_empty),
        .count     ()
    );

    // back end: memory write or read pair, multiply, then output
    slpi_back #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_BITS    (ADDR_BITS),
        .CMD_BITS     (CMD_BITS),
        .OCNT_BITS    (OCNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_data     (cmd_rdata),
        .cmd_pop      (cmd_pop),
        .out_count    (out_count),
        .out_push     (out_push),
        .out_data     (out_wdata)
    );

    // output queue: results wait here; a consumer stall only reaches the front once both queues fill
    slpi_fifo #(
        .WIDTH     (SAMPLE_BITS + 1),
        .DEPTH     (OUT_DEPTH),
        .CNT_BITS  (OCNT_BITS)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_wdata),
        .full      (),
        .pop       (pop),
        .pop_data  (out_rdata),
        .empty     (empty),
        .count     (out_count)
    );

    assign audio_out     = out_rdata[SAMPLE_BITS:1];
    assign still_playing = out_rdata[0];

endmodule

`default_nettype wire
